// ===== hw/rtl/i2cbb_pkg.sv =====
// Shared types and constants for the I2C bit-bang master sequencer.
`default_nettype none

package i2cbb_pkg;

   // Width of the clock-stretch timeout counters and registers
   localparam int TIMEOUT_BITS = 12;
   localparam int CMD_BITS     = 3;
   localparam int WORD_BITS    = 16;
   localparam int DATA_BITS    = 8;
   localparam int CNT_BITS     = 4;
   localparam int CSR_IDX_BITS = 2;

   // Command codes
   localparam logic [CMD_BITS-1:0] CMD_NONE  = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_START = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_STOP  = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_WRITE = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_READ  = 3'd4;
   localparam logic [CMD_BITS-1:0] CMD_ADDR  = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BYTE_TIMEOUT  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BIT_TIMEOUT   = 2'd2;

   // Register reset values
   localparam logic [TIMEOUT_BITS-1:0] START_TIMEOUT_RST = TIMEOUT_BITS'(275);
   localparam logic [TIMEOUT_BITS-1:0] BYTE_TIMEOUT_RST  = TIMEOUT_BITS'(20);
   localparam logic [TIMEOUT_BITS-1:0] BIT_TIMEOUT_RST   = TIMEOUT_BITS'(20);

   // Address byte forms that need a second byte: 10-bit (11110xxx), general call (0000000x)
   localparam logic [DATA_BITS-1:0] ADDR10_MASK = 8'hF8;
   localparam logic [DATA_BITS-1:0] ADDR10_CODE = 8'hF0;
   localparam logic [DATA_BITS-1:0] GCALL_MASK  = 8'hFE;
   localparam logic [DATA_BITS-1:0] GCALL_CODE  = 8'h00;

   typedef enum logic [4:0] {
      PH_IDLE      = 5'd0,
      PH_S_RAISE   = 5'd1,
      PH_S_POLL    = 5'd2,
      PH_S_SDALO   = 5'd3,
      PH_S_SCLLO   = 5'd4,
      PH_W_SDA     = 5'd5,
      PH_W_RAISE   = 5'd6,
      PH_W_POLL    = 5'd7,
      PH_W_SCLLO   = 5'd8,
      PH_W_ASDA    = 5'd9,
      PH_W_ARAISE  = 5'd10,
      PH_W_APOLL   = 5'd11,
      PH_W_ASCLLO  = 5'd12,
      PH_W_FAILSDA = 5'd13,
      PH_R_SDA     = 5'd14,
      PH_R_RAISE   = 5'd15,
      PH_R_POLL    = 5'd16,
      PH_R_SCLLO   = 5'd17,
      PH_R_ASDA    = 5'd18,
      PH_R_ARAISE  = 5'd19,
      PH_R_APOLL   = 5'd20,
      PH_R_ASCLLO  = 5'd21,
      PH_R_END     = 5'd22,
      PH_R_FAILSDA = 5'd23,
      PH_P_SDALO   = 5'd24,
      PH_P_RAISE   = 5'd25,
      PH_P_POLL    = 5'd26,
      PH_P_SDAHI   = 5'd27
   } phase_type;

   // Line drive state
   typedef struct packed {
      logic scl_en;
      logic scl_level;
      logic sda_en;
      logic sda_level;
   } line_type;

   // One request item
   typedef struct packed {
      logic [CMD_BITS-1:0]  cmd;
      logic [WORD_BITS-1:0] cmd_data;
      logic                 last_byte;
      logic                 tick;
      logic                 scl_in;
      logic                 sda_in;
   } req_type;

   // One result item
   typedef struct packed {
      line_type             line;
      logic                 busy;
      logic                 done;
      logic                 ack_ok;
      logic [DATA_BITS-1:0] read_byte;
   } rsp_type;

   // Timeout register set
   typedef struct packed {
      logic [TIMEOUT_BITS-1:0] start_tmo;
      logic [TIMEOUT_BITS-1:0] byte_tmo;
      logic [TIMEOUT_BITS-1:0] bit_tmo;
   } tmo_type;

endpackage

`default_nettype wire

// ===== hw/rtl/i2cbb_seq.sv =====
// Bus sequencer: phase state, shift/count/timeout registers and one-step next-state logic.
`default_nettype none

module i2cbb_seq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire i2cbb_pkg::req_type req,
   input  wire i2cbb_pkg::tmo_type tmo,
   output i2cbb_pkg::rsp_type      rsp
);
   import i2cbb_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [CNT_BITS-1:0]     bit_ff, bit_in;
   logic [DATA_BITS-1:0]    shift_ff, shift_in;
   logic [TIMEOUT_BITS-1:0] wait_ff, wait_in;
   logic [CMD_BITS-1:0]     lcmd_ff, lcmd_in;
   logic [WORD_BITS-1:0]    lword_ff, lword_in;
   logic                    llast_ff, llast_in;
   logic                    second_ff, second_in;
   line_type                line_ff, line_in;

   logic                    res_done, res_ok;
   logic [DATA_BITS-1:0]    res_data;
   logic                    wend, wend_ok;
   logic                    bbyte;
   logic [DATA_BITS-1:0]    bbyte_val;
   logic [TIMEOUT_BITS-1:0] wait_dec;
   logic                    poll_to;
   logic [CNT_BITS-1:0]     bit_inc;
   logic [DATA_BITS-1:0]    shift_shl;
   logic [DATA_BITS-1:0]    lo_byte;
   logic                    need_second;

   assign wait_dec    = wait_ff - 1'b1;
   assign poll_to     = (wait_dec == '0);
   assign bit_inc     = bit_ff + 1'b1;
   assign shift_shl   = {shift_ff[DATA_BITS-2:0], 1'b0};
   assign lo_byte     = lword_ff[DATA_BITS-1:0];
   assign need_second = ((lo_byte & ADDR10_MASK) == ADDR10_CODE) ||
                        ((lo_byte & GCALL_MASK) == GCALL_CODE);

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         bit_ff    <= '0;
         shift_ff  <= '0;
         wait_ff   <= '0;
         lcmd_ff   <= CMD_NONE;
         lword_ff  <= '0;
         llast_ff  <= 1'b0;
         second_ff <= 1'b0;
         line_ff   <= '{scl_en: 1'b0, scl_level: 1'b1, sda_en: 1'b0, sda_level: 1'b1};
      end else begin
         phase_ff  <= phase_in;
         bit_ff    <= bit_in;
         shift_ff  <= shift_in;
         wait_ff   <= wait_in;
         lcmd_ff   <= lcmd_in;
         lword_ff  <= lword_in;
         llast_ff  <= llast_in;
         second_ff <= second_in;
         line_ff   <= line_in;
      end
   end

   // Next state for one step
   always_comb begin
      phase_in  = phase_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      wait_in   = wait_ff;
      lcmd_in   = lcmd_ff;
      lword_in  = lword_ff;
      llast_in  = llast_ff;
      second_in = second_ff;
      line_in   = line_ff;
      res_done  = 1'b0;
      res_ok    = 1'b0;
      res_data  = '0;
      wend      = 1'b0;
      wend_ok   = 1'b0;
      bbyte     = 1'b0;
      bbyte_val = '0;

      if (step) begin
         if (phase_ff == PH_IDLE) begin
            // Command acceptance; first line action happens now
            unique case (req.cmd)
               CMD_START: begin
                  lcmd_in           = req.cmd;
                  line_in.scl_en    = 1'b1;
                  line_in.scl_level = 1'b1;
                  phase_in          = PH_S_RAISE;
               end
               CMD_ADDR: begin
                  lcmd_in           = req.cmd;
                  lword_in          = req.cmd_data;
                  second_in         = 1'b0;
                  line_in.scl_en    = 1'b1;
                  line_in.scl_level = 1'b1;
                  phase_in          = PH_S_RAISE;
               end
               CMD_STOP: begin
                  lcmd_in           = req.cmd;
                  line_in.sda_en    = 1'b1;
                  line_in.sda_level = 1'b0;
                  phase_in          = PH_P_SDALO;
               end
               CMD_WRITE: begin
                  lcmd_in   = req.cmd;
                  lword_in  = req.cmd_data;
                  bbyte     = 1'b1;
                  bbyte_val = req.cmd_data[DATA_BITS-1:0];
               end
               CMD_READ: begin
                  lcmd_in           = req.cmd;
                  llast_in          = req.last_byte;
                  shift_in          = '0;
                  bit_in            = '0;
                  line_in.sda_en    = 1'b1;
                  line_in.sda_level = 1'b1;
                  phase_in          = PH_R_SDA;
               end
               default: ;
            endcase
         end else if (req.tick) begin
            unique case (phase_ff)
               // Start condition
               PH_S_RAISE: begin
                  if (tmo.start_tmo == '0) begin
                     phase_in = PH_IDLE; res_done = 1'b1;
                  end else begin
                     line_in.scl_en = 1'b0; wait_in = tmo.start_tmo; phase_in = PH_S_POLL;
                  end
               end
               PH_S_POLL: begin
                  if (req.scl_in) begin
                     line_in.sda_en = 1'b1; line_in.sda_level = 1'b0; phase_in = PH_S_SDALO;
                  end else begin
                     wait_in = wait_dec;
                     if (poll_to) begin
                        phase_in = PH_IDLE; res_done = 1'b1;
                     end
                  end
               end
               PH_S_SDALO: begin
                  line_in.scl_en = 1'b1; line_in.scl_level = 1'b0; phase_in = PH_S_SCLLO;
               end
               PH_S_SCLLO: begin
                  if (lcmd_ff == CMD_ADDR) begin
                     bbyte = 1'b1; bbyte_val = lo_byte;
                  end else begin
                     phase_in = PH_IDLE; res_done = 1'b1; res_ok = 1'b1;
                  end
               end
               // Byte write
               PH_W_SDA: begin
                  line_in.scl_en = 1'b1; line_in.scl_level = 1'b1; phase_in = PH_W_RAISE;
               end
               PH_W_RAISE: begin
                  if (tmo.byte_tmo == '0) begin
                     line_in.sda_en = 1'b1; line_in.sda_level = 1'b1; phase_in = PH_W_FAILSDA;
                  end else begin
                     line_in.scl_en = 1'b0; wait_in = tmo.byte_tmo; phase_in = PH_W_POLL;
                  end
               end
               PH_W_POLL: begin
                  if (req.scl_in) begin
                     line_in.scl_en = 1'b1; line_in.scl_level = 1'b0; phase_in = PH_W_SCLLO;
                  end else begin
                     wait_in = wait_dec;
                     if (poll_to) begin
                        line_in.sda_en = 1'b1; line_in.sda_level = 1'b1;
                        phase_in = PH_W_FAILSDA;
                     end
                  end
               end
               PH_W_SCLLO: begin
                  bit_in   = bit_inc;
                  shift_in = shift_shl;
                  line_in.sda_en = 1'b1;
                  if (!bit_inc[CNT_BITS-1]) begin
                     line_in.sda_level = shift_shl[DATA_BITS-1]; phase_in = PH_W_SDA;
                  end else begin
                     line_in.sda_level = 1'b1; phase_in = PH_W_ASDA;
                  end
               end
               PH_W_ASDA: begin
                  line_in.scl_en = 1'b1; line_in.scl_level = 1'b1; phase_in = PH_W_ARAISE;
               end
               PH_W_ARAISE: begin
                  if (tmo.byte_tmo == '0) begin
                     wend = 1'b1;
                  end else begin
                     line_in.scl_en = 1'b0; wait_in = tmo.byte_tmo; phase_in = PH_W_APOLL;
                  end
               end
               PH_W_APOLL: begin
                  if (req.scl_in) begin
                     shift_in = DATA_BITS'(req.sda_in);
                     line_in.sda_en = 1'b0;
                     line_in.scl_en = 1'b1; line_in.scl_level = 1'b0;
                     phase_in = PH_W_ASCLLO;
                  end else begin
                     wait_in = wait_dec;
                     if (poll_to) wend = 1'b1;
                  end
               end
               PH_W_ASCLLO: begin
                  wend = 1'b1; wend_ok = (shift_ff == '0);
               end
               PH_W_FAILSDA: begin
                  wend = 1'b1;
               end
               // Byte read
               PH_R_SDA: begin
                  line_in.scl_en = 1'b1; line_in.scl_level = 1'b1; phase_in = PH_R_RAISE;
               end
               PH_R_RAISE: begin
                  if (tmo.bit_tmo == '0) begin
                     phase_in = PH_IDLE; res_done = 1'b1;
                  end else begin
                     line_in.scl_en = 1'b0; wait_in = tmo.bit_tmo; phase_in = PH_R_POLL;
                  end
               end
               PH_R_POLL: begin
                  if (req.scl_in) begin
                     shift_in = {shift_ff[DATA_BITS-2:0], req.sda_in};
                     line_in.sda_en = 1'b0;
                     line_in.scl_en = 1'b1; line_in.scl_level = 1'b0;
                     phase_in = PH_R_SCLLO;
                  end else begin
                     wait_in = wait_dec;
                     if (poll_to) begin
                        phase_in = PH_IDLE; res_done = 1'b1;
                     end
                  end
               end
               PH_R_SCLLO: begin
                  bit_in = bit_inc;
                  if (!bit_inc[CNT_BITS-1]) begin
                     line_in.scl_en = 1'b1; line_in.scl_level = 1'b1; phase_in = PH_R_RAISE;
                  end else begin
                     line_in.sda_en = 1'b1; line_in.sda_level = llast_ff; phase_in = PH_R_ASDA;
                  end
               end
               PH_R_ASDA: begin
                  line_in.scl_en = 1'b1; line_in.scl_level = 1'b1; phase_in = PH_R_ARAISE;
               end
               PH_R_ARAISE: begin
                  if (tmo.bit_tmo == '0) begin
                     line_in.sda_en = 1'b1; line_in.sda_level = 1'b1; phase_in = PH_R_FAILSDA;
                  end else begin
                     line_in.scl_en = 1'b0; wait_in = tmo.bit_tmo; phase_in = PH_R_APOLL;
                  end
               end
               PH_R_APOLL: begin
                  if (req.scl_in) begin
                     line_in.scl_en = 1'b1; line_in.scl_level = 1'b0; phase_in = PH_R_ASCLLO;
                  end else begin
                     wait_in = wait_dec;
                     if (poll_to) begin
                        line_in.sda_en = 1'b1; line_in.sda_level = 1'b1;
                        phase_in = PH_R_FAILSDA;
                     end
                  end
               end
               PH_R_ASCLLO: begin
                  line_in.sda_en = 1'b1; line_in.sda_level = 1'b1; phase_in = PH_R_END;
               end
               PH_R_END: begin
                  phase_in = PH_IDLE; res_done = 1'b1; res_ok = 1'b1; res_data = shift_ff;
               end
               PH_R_FAILSDA: begin
                  phase_in = PH_IDLE; res_done = 1'b1;
               end
               // Stop condition; shift_ff[0] carries the SCL-rise result
               PH_P_SDALO: begin
                  line_in.scl_en = 1'b1; line_in.scl_level = 1'b1; phase_in = PH_P_RAISE;
               end
               PH_P_RAISE: begin
                  if (tmo.byte_tmo == '0) begin
                     shift_in = '0;
                     line_in.sda_en = 1'b1; line_in.sda_level = 1'b1; phase_in = PH_P_SDAHI;
                  end else begin
                     line_in.scl_en = 1'b0; wait_in = tmo.byte_tmo; phase_in = PH_P_POLL;
                  end
               end
               PH_P_POLL: begin
                  if (req.scl_in) begin
                     shift_in = DATA_BITS'(1);
                     line_in.sda_en = 1'b1; line_in.sda_level = 1'b1; phase_in = PH_P_SDAHI;
                  end else begin
                     wait_in = wait_dec;
                     if (poll_to) begin
                        shift_in = '0;
                        line_in.sda_en = 1'b1; line_in.sda_level = 1'b1;
                        phase_in = PH_P_SDAHI;
                     end
                  end
               end
               PH_P_SDAHI: begin
                  phase_in = PH_IDLE; res_done = 1'b1;
                  res_ok   = (lcmd_ff != CMD_ADDR) && shift_ff[0];
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end

      // End of a written byte: finish, stop on failure, or send the address high byte
      if (wend) begin
         if (lcmd_ff != CMD_ADDR) begin
            phase_in = PH_IDLE; res_done = 1'b1; res_ok = wend_ok;
         end else if (!wend_ok) begin
            line_in.sda_en = 1'b1; line_in.sda_level = 1'b0; phase_in = PH_P_SDALO;
         end else if (!second_ff && need_second) begin
            second_in = 1'b1;
            bbyte     = 1'b1;
            bbyte_val = lword_ff[WORD_BITS-1:DATA_BITS];
         end else begin
            phase_in = PH_IDLE; res_done = 1'b1; res_ok = 1'b1;
         end
      end

      // Load a byte for transmit and put its MSB on SDA
      if (bbyte) begin
         shift_in          = bbyte_val;
         bit_in            = '0;
         line_in.sda_en    = 1'b1;
         line_in.sda_level = bbyte_val[DATA_BITS-1];
         phase_in          = PH_W_SDA;
      end
   end

   // Result of this step
   always_comb begin
      rsp.line      = line_in;
      rsp.busy      = (phase_in != PH_IDLE);
      rsp.done      = res_done;
      rsp.ack_ok    = res_ok;
      rsp.read_byte = res_data;
   end

   // Checks
   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      res_done |-> (phase_in == PH_IDLE) && (phase_ff != PH_IDLE))
      else $error("done without return to idle");

   a_no_result_without_done: assert property (@(posedge clock) disable iff (reset)
      !res_done |-> !res_ok && (res_data == '0))
      else $error("ack or data outside done");

   a_hold_without_step: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(line_ff) && $stable(wait_ff))
      else $error("state moved without a step");

   a_poll_countdown: assert property (@(posedge clock) disable iff (reset)
      (step && req.tick && !req.scl_in && (phase_ff == PH_W_POLL || phase_ff == PH_R_POLL ||
       phase_ff == PH_S_POLL || phase_ff == PH_P_POLL))
      |=> wait_ff == TIMEOUT_BITS'($past(wait_ff) - 1'b1))
      else $error("stretch timeout did not count down");

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_bitbang_master_top.sv =====
// Top level of the I2C bit-bang master: request/result registers and timeout registers.
//
// Usage:
//  - Request channel (req_*): one item per bus step, carrying the command, its data,
//    the tick strobe and the sampled SCL/SDA pins. A request is taken on a rising edge
//    with req_valid high and req_stall low.
//  - Result channel (rsp_*): exactly one result per request, in order: line drive,
//    busy, done, ack_ok and the read byte. Taken on an edge with rsp_valid high and
//    rsp_stall low.
//  - Register port (csr_*): index 0 start_timeout, 1 byte_timeout, 2 bit_timeout;
//    csr_ready is always high. Write only while no request is in flight.
//  - Throughput: one request per cycle while no result waits on rsp_stall; the one-step
//    sequencer update sits between the request register and the result register.
//  - Stall: while rsp_stall holds a waiting result, the request register still takes
//    one more request; req_stall rises only when both registers are full.
//  - Reset: sequencer idle, both lines released with levels high, timeouts at
//    275/20/20, both registers empty.
`default_nettype none

module i2c_bitbang_master_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [i2cbb_pkg::CMD_BITS-1:0]       req_cmd,
   input  wire logic [i2cbb_pkg::WORD_BITS-1:0]      req_cmd_data,
   input  wire logic                                 req_last_byte,
   input  wire logic                                 req_tick,
   input  wire logic                                 req_scl_in,
   input  wire logic                                 req_sda_in,
   // Result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_scl_drive_en,
   output logic                                      rsp_scl_level,
   output logic                                      rsp_sda_drive_en,
   output logic                                      rsp_sda_level,
   output logic                                      rsp_busy_res,
   output logic                                      rsp_done_res,
   output logic                                      rsp_ack_ok,
   output logic [i2cbb_pkg::DATA_BITS-1:0]           rsp_read_byte,
   // Register write port
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [i2cbb_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [i2cbb_pkg::TIMEOUT_BITS-1:0]   csr_data
);
   import i2cbb_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff;
   tmo_type tmo_ff;
   rsp_type seq_rsp;
   logic    req_take;
   logic    step;

   // Handshake
   assign step      = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Request register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= '{cmd: req_cmd, cmd_data: req_cmd_data, last_byte: req_last_byte,
                    tick: req_tick, scl_in: req_scl_in, sda_in: req_sda_in};
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= seq_rsp;
      end
   end

   // Timeout registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tmo_ff.start_tmo <= START_TIMEOUT_RST;
         tmo_ff.byte_tmo  <= BYTE_TIMEOUT_RST;
         tmo_ff.bit_tmo   <= BIT_TIMEOUT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_TIMEOUT: tmo_ff.start_tmo <= csr_data;
            CSR_BYTE_TIMEOUT:  tmo_ff.byte_tmo  <= csr_data;
            CSR_BIT_TIMEOUT:   tmo_ff.bit_tmo   <= csr_data;
            default: ;
         endcase
      end
   end

   i2cbb_seq u_seq (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (in_ff),
      .tmo   (tmo_ff),
      .rsp   (seq_rsp)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_scl_drive_en = out_ff.line.scl_en;
   assign rsp_scl_level    = out_ff.line.scl_level;
   assign rsp_sda_drive_en = out_ff.line.sda_en;
   assign rsp_sda_level    = out_ff.line.sda_level;
   assign rsp_busy_res     = out_ff.busy;
   assign rsp_done_res     = out_ff.done;
   assign rsp_ack_ok       = out_ff.ack_ok;
   assign rsp_read_byte    = out_ff.read_byte;

endmodule

`default_nettype wire
